// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the ADC average/dead-band block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define DCAD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked in every cycle, reset included
`define DCAD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) \
        else $error(msg);
`else
`define DCAD_ASSERT(name, prop, msg)
`define DCAD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== sv/dcad_pkg.sv =====
// Shared types and constants of the ADC average/dead-band block.
// No dependencies.
`timescale 1ns / 1ps

package dcad_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int DEAD_BAND_W   = 10;
    localparam int IN_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TUSER_W   = 1;

    localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = DEAD_BAND_W'(8);
    localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX      = {SAMPLE_W{1'b1}};

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    // control fields that travel with an item down the pipeline
    typedef struct packed {
        logic op;
        logic ch;
        logic in_range;
    } t_ctrl;

endpackage

// ===== sv/dcad_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module dcad_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/dcad_ring.sv =====
// Input stage: per-channel ring position, fill state and preload value,
// plus the sample ring RAM. Depends on dcad_pkg and dcad_ram.
`timescale 1ns / 1ps

module dcad_ring #(
    parameter int WINDOW_DEPTH  = 8,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic                          i_channel,
    input  logic [dcad_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    output dcad_pkg::t_ctrl               o_ctrl,
    output logic [dcad_pkg::SAMPLE_W-1:0] o_sample,
    output logic [dcad_pkg::SAMPLE_W-1:0] o_old
);

    localparam int DEPTH_W   = $clog2(WINDOW_DEPTH);
    localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ADDR_W    = CH_W + DEPTH_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    logic [DEPTH_W-1:0]            r_pos  [CHANNEL_COUNT];
    logic                          r_full [CHANNEL_COUNT];
    logic [dcad_pkg::SAMPLE_W-1:0] r_base [CHANNEL_COUNT];

    logic                          r_s1_valid;
    dcad_pkg::t_ctrl               r_s1_ctrl;
    logic [dcad_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                          r_s1_full;
    logic [dcad_pkg::SAMPLE_W-1:0] r_s1_base;

    logic                          in_range;
    logic [CH_W-1:0]               idx;
    logic                          accept;
    logic                          do_sample;
    logic                          do_preload;
    logic [DEPTH_W-1:0]            pos;
    logic                          pos_last;
    logic [ADDR_W-1:0]             addr;
    logic [dcad_pkg::SAMPLE_W-1:0] ram_q;

    assign in_range   = {31'd0, i_channel} < 32'(CHANNEL_COUNT);
    assign idx        = in_range ? CH_W'(i_channel) : '0;
    assign accept     = i_en && i_valid;
    assign do_sample  = accept && in_range && (i_opcode == dcad_pkg::OP_SAMPLE);
    assign do_preload = accept && in_range && (i_opcode == dcad_pkg::OP_PRELOAD);
    assign pos        = r_pos[idx];
    assign pos_last   = (pos == DEPTH_W'(WINDOW_DEPTH - 1));
    assign addr       = {idx, pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_pos[i]  <= '0;
                r_full[i] <= 1'b0;
                r_base[i] <= '0;
            end
        end else begin
            if (i_en) begin
                r_s1_valid <= i_valid;
            end
            if (do_sample) begin
                r_pos[idx] <= pos_last ? '0 : pos + DEPTH_W'(1);
                if (pos_last) begin
                    r_full[idx] <= 1'b1;
                end
            end
            // preload: every slot reads as the preload value until rewritten
            if (do_preload) begin
                r_pos[idx]  <= '0;
                r_full[idx] <= 1'b0;
                r_base[idx] <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ctrl   <= '{op: i_opcode, ch: i_channel, in_range: in_range};
            r_s1_sample <= i_sample;
            r_s1_full   <= r_full[idx];
            r_s1_base   <= r_base[idx];
        end
    end

    dcad_ram #(
        .WIDTH (dcad_pkg::SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_sample),
        .i_wr_addr (addr),
        .i_wr_data (i_sample),
        .i_rd_en   (i_en),
        .i_rd_addr (addr),
        .o_rd_data (ram_q)
    );

    assign o_valid  = r_s1_valid;
    assign o_ctrl   = r_s1_ctrl;
    assign o_sample = r_s1_sample;
    assign o_old    = r_s1_full ? ram_q : r_s1_base;

endmodule

// ===== sv/dcad_sum.sv =====
// Running-sum stage: keeps each channel's window total.
// Depends on dcad_pkg.
`timescale 1ns / 1ps

module dcad_sum #(
    parameter int WINDOW_DEPTH  = 8,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  dcad_pkg::t_ctrl               i_ctrl,
    input  logic [dcad_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [dcad_pkg::SAMPLE_W-1:0] i_old,
    output logic                          o_valid,
    output dcad_pkg::t_ctrl               o_ctrl,
    output logic [dcad_pkg::SAMPLE_W-1:0] o_sample,
    output logic [dcad_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] o_sum
);

    localparam int DEPTH_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = dcad_pkg::SAMPLE_W + DEPTH_W;
    localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [SUM_W-1:0]              r_sum [CHANNEL_COUNT];
    logic                          r_s2_valid;
    dcad_pkg::t_ctrl               r_s2_ctrl;
    logic [dcad_pkg::SAMPLE_W-1:0] r_s2_sample;
    logic [SUM_W-1:0]              r_s2_sum;

    logic [CH_W-1:0]  idx;
    logic [SUM_W-1:0] n_sum;

    assign idx = i_ctrl.in_range ? CH_W'(i_ctrl.ch) : '0;

    always_comb begin
        if (i_ctrl.op == dcad_pkg::OP_PRELOAD) begin
            n_sum = SUM_W'(i_sample) * SUM_W'(WINDOW_DEPTH);
        end else begin
            n_sum = r_sum[idx] - SUM_W'(i_old) + SUM_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_en) begin
            r_s2_valid <= i_valid;
            if (i_valid && i_ctrl.in_range) begin
                r_sum[idx] <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ctrl   <= i_ctrl;
            r_s2_sample <= i_sample;
            r_s2_sum    <= n_sum;
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_ctrl   = r_s2_ctrl;
    assign o_sample = r_s2_sample;
    assign o_sum    = r_s2_sum;

endmodule

// ===== sv/dcad_hold.sv =====
// Average and dead-band stage: floor average by reciprocal multiply, held
// value update and the result register. Depends on dcad_pkg.
`timescale 1ns / 1ps

module dcad_hold #(
    parameter int WINDOW_DEPTH  = 8,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  dcad_pkg::t_ctrl                  i_ctrl,
    input  logic [dcad_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [dcad_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] i_sum,
    input  logic [dcad_pkg::DEAD_BAND_W-1:0] i_dead_band,
    output logic                             o_valid,
    output logic [dcad_pkg::SAMPLE_W-1:0]    o_held_a,
    output logic [dcad_pkg::SAMPLE_W-1:0]    o_held_b,
    output logic                             o_changed
);

    localparam int DEPTH_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = dcad_pkg::SAMPLE_W + DEPTH_W;
    localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    // floor(sum / depth) == (sum * RECIP) >> SHIFT for every sum below 2^SUM_W
    localparam int SHIFT   = SUM_W + DEPTH_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    localparam int SW = dcad_pkg::SAMPLE_W;

    logic [SW-1:0] r_held [CHANNEL_COUNT];
    logic          r_out_valid;
    logic [SW-1:0] r_out_held_a;
    logic [SW-1:0] r_out_held_b;
    logic          r_out_changed;

    logic [CH_W-1:0]   idx;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]     avg;
    logic [SW-1:0]     held;
    logic [SW-1:0]     diff;
    logic              band_hit;
    logic              n_changed;
    logic [SW-1:0]     n_value;
    logic [SW-1:0]     n_held [CHANNEL_COUNT];
    logic [SW-1:0]     n_held_b;

    assign idx  = i_ctrl.in_range ? CH_W'(i_ctrl.ch) : '0;
    assign prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign avg  = SW'(prod >> SHIFT);
    assign held = r_held[idx];
    assign diff = (avg > held) ? (avg - held) : (held - avg);

    // rails always update, even when equal to the held value
    assign band_hit  = (avg == '0) || (avg == dcad_pkg::SAMPLE_MAX) || (diff > i_dead_band);
    assign n_changed = i_valid && i_ctrl.in_range
                       && ((i_ctrl.op == dcad_pkg::OP_PRELOAD) || band_hit);
    assign n_value   = (i_ctrl.op == dcad_pkg::OP_PRELOAD) ? i_sample : avg;

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            n_held[i] = (n_changed && (idx == CH_W'(i))) ? n_value : r_held[i];
        end
    end

    generate
        if (CHANNEL_COUNT > 1) begin : g_two
            assign n_held_b = n_held[1];
        end else begin : g_one
            assign n_held_b = '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_en) begin
            r_out_valid <= i_valid;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_held[i] <= n_held[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_held_a  <= n_held[0];
            r_out_held_b  <= n_held_b;
            r_out_changed <= n_changed;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_held_a  = r_out_held_a;
    assign o_held_b  = r_out_held_b;
    assign o_changed = r_out_changed;

endmodule

// ===== sv/dual_channel_adc_average_deadband.sv =====
// Two-channel ADC moving average with dead band, top level.
// Results pass the ring, sum and hold stage registers; one item per cycle unless the output stalls.
// Rate is set by the three-stage pipeline (ring RAM read, running sum,
// reciprocal-multiply average and dead-band compare), stalled as a whole.
// Synchronous active-low reset clears rings, sums, held values, dead band = 8.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_channel_adc_average_deadband #(
    parameter int WINDOW_DEPTH  = 8,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dcad_pkg::DEAD_BAND_W-1:0]    i_cfg_wdata,   // dead_band
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dcad_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [9:0] sample
    input  logic [dcad_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [0] opcode, [1] channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dcad_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [9:0] held_value_a,
                                                               // [19:10] held_value_b
    output logic [dcad_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // [0] changed
);

    localparam int SW    = dcad_pkg::SAMPLE_W;
    localparam int SUM_W = SW + $clog2(WINDOW_DEPTH);

    logic [dcad_pkg::DEAD_BAND_W-1:0] r_dead_band;

    logic            pipe_en;
    logic            s1_valid;
    dcad_pkg::t_ctrl s1_ctrl;
    logic [SW-1:0]   s1_sample;
    logic [SW-1:0]   s1_old;
    logic            s2_valid;
    dcad_pkg::t_ctrl s2_ctrl;
    logic [SW-1:0]   s2_sample;
    logic [SUM_W-1:0] s2_sum;
    logic            out_valid;
    logic [SW-1:0]   out_held_a;
    logic [SW-1:0]   out_held_b;
    logic            out_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band <= dcad_pkg::DEAD_BAND_RESET;
        end else if (i_cfg_we) begin
            r_dead_band <= i_cfg_wdata;
        end
    end

    // whole pipeline advances when the result register is free or being taken
    assign pipe_en       = !out_valid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    dcad_ring #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (s_axis_tvalid),
        .i_opcode  (s_axis_tuser[0]),
        .i_channel (s_axis_tuser[1]),
        .i_sample  (s_axis_tdata[SW-1:0]),
        .o_valid   (s1_valid),
        .o_ctrl    (s1_ctrl),
        .o_sample  (s1_sample),
        .o_old     (s1_old)
    );

    dcad_sum #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (s1_valid),
        .i_ctrl   (s1_ctrl),
        .i_sample (s1_sample),
        .i_old    (s1_old),
        .o_valid  (s2_valid),
        .o_ctrl   (s2_ctrl),
        .o_sample (s2_sample),
        .o_sum    (s2_sum)
    );

    dcad_hold #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_hold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (s2_valid),
        .i_ctrl      (s2_ctrl),
        .i_sample    (s2_sample),
        .i_sum       (s2_sum),
        .i_dead_band (r_dead_band),
        .o_valid     (out_valid),
        .o_held_a    (out_held_a),
        .o_held_b    (out_held_b),
        .o_changed   (out_changed)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {(dcad_pkg::OUT_TDATA_W - 2 * SW)'(0), out_held_b, out_held_a};
    assign m_axis_tuser  = out_changed;

    // a preload of channel 0 shows up flagged and with its reading as held value
    `DCAD_ASSERT(a_preload_result,
        (pipe_en && s2_valid && s2_ctrl.in_range
         && s2_ctrl.op == dcad_pkg::OP_PRELOAD && !s2_ctrl.ch)
        |=> (m_axis_tvalid && m_axis_tuser[0]
             && m_axis_tdata[SW-1:0] == $past(s2_sample)),
        "preload result mismatch")
    // an item for a channel that does not exist never reports a change
    `DCAD_ASSERT(a_no_change_out_of_range,
        (pipe_en && s2_valid && !s2_ctrl.in_range) |=> !m_axis_tuser[0],
        "change flagged for absent channel")
    `DCAD_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid,
        "result valid after reset")

endmodule

// ===== bench/dual_channel_adc_average_deadband_test.sv =====
// Testbench for dual_channel_adc_average_deadband: directed and random sample/preload items
// against a behavioral copy of the ring average and dead band. Depends on dcad_pkg and the top.
`timescale 1ns / 1ps

module dual_channel_adc_average_deadband_test;

    localparam int RING_DEPTH   = 8;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        logic [dcad_pkg::SAMPLE_W-1:0] held_a;
        logic [dcad_pkg::SAMPLE_W-1:0] held_b;
        logic                          changed;
    } t_held_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [dcad_pkg::DEAD_BAND_W-1:0]    i_cfg_wdata = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [dcad_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;   // [9:0] sample
    logic [dcad_pkg::IN_TUSER_W-1:0]     s_axis_tuser = '0;   // [0] opcode, [1] channel
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [dcad_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;  // [9:0] held_value_a, [19:10] held_value_b
    logic [dcad_pkg::OUT_TUSER_W-1:0]    m_axis_tuser;  // [0] changed

    // local copy of the block state
    logic [dcad_pkg::SAMPLE_W-1:0]       ring [2][RING_DEPTH];
    logic [2:0]                          ring_pos [2];
    logic [12:0]                         ring_sum [2];
    logic [dcad_pkg::SAMPLE_W-1:0]       held [2];
    logic [dcad_pkg::DEAD_BAND_W-1:0]    band;

    t_held_result             hold_queue [$];
    int                       error_count = 0;
    int                       item_count = 0;
    int                       preload_count = 0;
    int                       result_count = 0;
    int                       change_count = 0;
    int                       cycle_count = 0;
    int                       stall_left = 0;
    bit                       idle_on = 1'b1;

    dual_channel_adc_average_deadband i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     hold_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls in random bursts while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_held_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (hold_queue.size() == 0) begin
                $error("result with no item pending: a=%0d b=%0d changed=%0d",
                       m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tuser[0]);
                error_count++;
            end else begin
                exp_res = hold_queue.pop_front();
                if (m_axis_tdata[9:0] !== exp_res.held_a) begin
                    $error("held_value_a: expected %0d, actual %0d", exp_res.held_a,
                           m_axis_tdata[9:0]);
                    error_count++;
                end
                if (m_axis_tdata[19:10] !== exp_res.held_b) begin
                    $error("held_value_b: expected %0d, actual %0d", exp_res.held_b,
                           m_axis_tdata[19:10]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== exp_res.changed) begin
                    $error("changed: expected %0d, actual %0d", exp_res.changed,
                           m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // update the local state for one accepted item and queue the result it must give
    task automatic smooth_and_hold(input logic op, input logic ch,
                                   input logic [dcad_pkg::SAMPLE_W-1:0] smp);
        t_held_result res;
        logic [dcad_pkg::SAMPLE_W-1:0] avg;
        logic [dcad_pkg::SAMPLE_W-1:0] diff;
        logic chg;
        chg = 1'b0;
        if (op == dcad_pkg::OP_PRELOAD) begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring[ch][i] = smp;
            ring_pos[ch] = '0;
            ring_sum[ch] = 13'(13'(smp) * RING_DEPTH);
            held[ch] = smp;
            chg = 1'b1;
            preload_count++;
        end else begin
            ring_sum[ch] = ring_sum[ch] - 13'(ring[ch][ring_pos[ch]]) + 13'(smp);
            ring[ch][ring_pos[ch]] = smp;
            ring_pos[ch] = ring_pos[ch] + 3'd1;
            avg = dcad_pkg::SAMPLE_W'(ring_sum[ch] / RING_DEPTH);
            diff = (avg > held[ch]) ? avg - held[ch] : held[ch] - avg;
            // rails always take, even when equal to the held value
            if (avg == '0 || avg == dcad_pkg::SAMPLE_MAX || diff > band) begin
                held[ch] = avg;
                chg = 1'b1;
            end
        end
        res.held_a = held[0];
        res.held_b = held[1];
        res.changed = chg;
        if (chg)
            change_count++;
        hold_queue.push_back(res);
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic op, input logic ch,
                             input logic [dcad_pkg::SAMPLE_W-1:0] smp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= dcad_pkg::IN_TDATA_W'(smp);
        s_axis_tuser  <= {ch, op};
        do @(posedge i_clk); while (!s_axis_tready);
        item_count++;
        smooth_and_hold(op, ch, smp);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (hold_queue.size() != 0)
            @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_dead_band(input logic [dcad_pkg::DEAD_BAND_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        band = value;
    endtask

    // mostly readings near the held value so the dead band decides; some noise, rail values and preloads
    task automatic send_random_items(input int count);
        logic ch;
        logic op;
        int   val;
        int   pick;
        for (int n = 0; n < count; n++) begin
            ch = 1'($urandom_range(0, 1));
            op = dcad_pkg::OP_SAMPLE;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                op = dcad_pkg::OP_PRELOAD;
                val = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 1023 : 0)
                                                   : int'($urandom_range(0, 1023));
            end else if (pick < 20) begin
                val = int'($urandom_range(0, 1023));
            end else if (pick < 28) begin
                val = $urandom_range(0, 1) ? 1023 : 0;
            end else begin
                val = int'(held[ch]) + int'($urandom_range(0, 80)) - 40;
                if (val < 0)
                    val = 0;
                if (val > 1023)
                    val = 1023;
            end
            send_item(op, ch, dcad_pkg::SAMPLE_W'(val));
        end
    endtask

    task automatic test_directed_cases();
        // rail at zero takes even though it equals the held value
        send_item(dcad_pkg::OP_SAMPLE, 1'b0, 10'd0);
        send_item(dcad_pkg::OP_PRELOAD, 1'b0, 10'd1023);
        send_item(dcad_pkg::OP_SAMPLE, 1'b0, 10'd1023);
        send_item(dcad_pkg::OP_PRELOAD, 1'b1, 10'd512);
        send_item(dcad_pkg::OP_SAMPLE, 1'b1, 10'd520);     // inside the band
        send_item(dcad_pkg::OP_SAMPLE, 1'b1, 10'd600);     // outside the band
        send_item(dcad_pkg::OP_PRELOAD, 1'b1, 10'd0);      // channel 0 must stay put
        repeat (8) send_item(dcad_pkg::OP_SAMPLE, 1'b1, 10'd1023);   // climbs to the top rail
        send_item(dcad_pkg::OP_PRELOAD, 1'b0, 10'd5);
        send_item(dcad_pkg::OP_SAMPLE, 1'b0, 10'd13);
        // difference exactly equal to the band does not take, a larger one does
        send_item(dcad_pkg::OP_PRELOAD, 1'b0, 10'd100);
        send_item(dcad_pkg::OP_SAMPLE, 1'b0, 10'd164);
        send_item(dcad_pkg::OP_SAMPLE, 1'b0, 10'd172);
        wait_drained();
    endtask

    task automatic test_band_zero();
        write_dead_band('0);
        send_random_items(130);
        wait_drained();
    endtask

    task automatic test_band_max();
        // only rails and preloads can change the held value here
        write_dead_band('1);
        send_random_items(130);
        wait_drained();
    endtask

    task automatic test_band_random();
        write_dead_band(dcad_pkg::DEAD_BAND_W'($urandom_range(1, 1022)));
        send_random_items(150);
        wait_drained();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        write_dead_band(dcad_pkg::DEAD_BAND_RESET);
        send_random_items(140);
        wait_drained();
    endtask

    initial begin
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring[c][i] = '0;
            ring_pos[c] = '0;
            ring_sum[c] = '0;
            held[c] = '0;
        end
        band = dcad_pkg::DEAD_BAND_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_band_zero();
        test_band_max();
        test_band_random();
        test_full_rate();

        repeat (10) @(posedge i_clk);
        $display("%0d items sent (%0d preloads), %0d results checked, %0d held-value updates",
                 item_count, preload_count, result_count, change_count);
        $display("dead band 8, 0, 1023 and a random value; last phase at full rate");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/dcad_pkg.sv
sv/dcad_ram.sv
sv/dcad_ring.sv
sv/dcad_sum.sv
sv/dcad_hold.sv
sv/dual_channel_adc_average_deadband.sv
bench/dual_channel_adc_average_deadband_test.sv
